### rtl/prqs_pkg.sv
// Shared widths, request and status codes, and cell control type for the ready queue scheduler.
`default_nettype none
package prqs_pkg;

  localparam int REQ_W    = 3;
  localparam int ID_W     = 6;
  localparam int PRIO_W   = 5;
  localparam int CHOSEN_W = 6;
  localparam int STATUS_W = 3;
  localparam int READY_W  = 6;

  localparam int DEF_PRIO_LEVELS = 32;
  localparam int DEF_TASK_SLOTS  = 64;

  typedef enum logic [REQ_W-1:0] {
    REQ_ADD    = 3'd0,
    REQ_PICK   = 3'd1,
    REQ_SWITCH = 3'd2,
    REQ_LOCK   = 3'd3,
    REQ_UNLOCK = 3'd4
  } req_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE      = 3'd0,
    ST_KEPT      = 3'd1,
    ST_EMPTY     = 3'd2,
    ST_DEFERRED  = 3'd3,
    ST_LOCKED    = 3'd4,
    ST_UNLOCKED  = 3'd5
  } status_t;

  typedef struct packed {
    logic enq;
    logic clr;
    logic hld;
  } cell_ctl_t;

endpackage
`default_nettype wire

### rtl/prqs_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module prqs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

### rtl/prqs_cell.sv
// One priority level cell: list head, list tail and busy flag, chained for top search.
`default_nettype none
module prqs_cell #(
  parameter int LEVEL = 0,
  parameter int LW    = 5,
  parameter int TW    = 6
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire prqs_pkg::cell_ctl_t ctl,
  input  wire logic [LW-1:0]       enq_lv,
  input  wire logic [LW-1:0]       deq_lv,
  input  wire logic [TW-1:0]       tid,
  input  wire logic [TW-1:0]       head_val,
  input  wire logic                found_in,
  output logic                     found_out,
  output logic                     is_top,
  output logic                     busy,
  output logic      [TW-1:0]       head,
  output logic      [TW-1:0]       tail
);
  import prqs_pkg::*;

  localparam logic [LW-1:0] ME = LW'(LEVEL);

  logic enq_hit;
  logic deq_hit;
  logic busy_next;

  assign enq_hit   = ctl.enq && (enq_lv == ME);
  assign deq_hit   = deq_lv == ME;
  assign is_top    = busy && !found_in;
  assign found_out = found_in || busy;

  always_comb begin
    busy_next = busy;
    if (enq_hit) begin
      busy_next = 1'b1;
    end
    if (ctl.clr && deq_hit) begin
      busy_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else begin
      busy <= busy_next;
    end
  end

  always_ff @(posedge clk) begin
    if (enq_hit) begin
      tail <= tid;
      if (!busy) begin
        head <= tid;
      end
    end else if (ctl.hld && deq_hit) begin
      head <= head_val;
    end
  end

endmodule
`default_nettype wire

### rtl/priority_ready_queue_scheduler.sv
// Top level: fixed-priority ready queue built from a chain of per-level cells and a link RAM.
// An accepted request goes to S_LINK or S_FIN, which loads its result once the output is free.
// A pop that leaves its level non-empty uses S_LINK to load the new list head
// from the registered link RAM read; other requests use S_FIN to read the updated top level.
// No new request is taken until the last one has loaded its result; a stalled result holds
// the next request in S_LINK or S_FIN and stalls the input until the result is taken.
// Reset empties every level and unlocks switching; the link RAM is not cleared.
`default_nettype none
module priority_ready_queue_scheduler #(
  parameter int PRIO_LEVELS = prqs_pkg::DEF_PRIO_LEVELS,
  parameter int TASK_SLOTS  = prqs_pkg::DEF_TASK_SLOTS
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          req_valid,
  output logic                               req_stall,
  input  wire logic [prqs_pkg::REQ_W-1:0]    req_type,
  input  wire logic [prqs_pkg::ID_W-1:0]     task_id,
  input  wire logic [prqs_pkg::PRIO_W-1:0]   task_prio,
  output logic                               res_valid,
  input  wire logic                          res_stall,
  output logic      [prqs_pkg::CHOSEN_W-1:0] chosen_task,
  output logic      [prqs_pkg::STATUS_W-1:0] status,
  output logic      [prqs_pkg::READY_W-1:0]  ready_highest
);
  import prqs_pkg::*;

  localparam int LW = $clog2(PRIO_LEVELS);
  localparam int TW = $clog2(TASK_SLOTS);
  localparam int RW = $clog2(PRIO_LEVELS + 1);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_LINK = 3'b010,
    S_FIN  = 3'b100
  } state_t;

  function automatic logic [TW-1:0] wrap_tid(input logic [ID_W-1:0] v);
    int r;
    r = int'(v);
    for (int i = ID_W - 1; i >= 0; i--) begin
      if (r >= (TASK_SLOTS << i)) begin
        r = r - (TASK_SLOTS << i);
      end
    end
    return TW'(r);
  endfunction

  state_t state, state_next;
  logic   locked, locked_next;

  logic [TW-1:0]       tid_in;
  logic [LW-1:0]       lv_in;
  logic                acc;
  logic                out_free;

  cell_ctl_t           ctl;
  logic [LW-1:0]       deq_lv;
  logic [TW-1:0]       head_val;
  logic [PRIO_LEVELS:0] found;
  logic                is_top    [PRIO_LEVELS];
  logic                cell_busy [PRIO_LEVELS];
  logic [TW-1:0]       cell_head [PRIO_LEVELS];
  logic [TW-1:0]       cell_tail [PRIO_LEVELS];

  logic [LW-1:0]       top_lv;
  logic [RW-1:0]       top_idx;
  logic                top_none;
  logic [TW-1:0]       top_head;
  logic [TW-1:0]       top_tail;
  logic                lv_busy;
  logic [TW-1:0]       lv_tail;
  logic [TW-1:0]       tail_after;

  logic                ram_we;
  logic [TW-1:0]       ram_waddr;
  logic [TW-1:0]       ram_raddr;
  logic [TW-1:0]       ram_q;

  logic [LW-1:0]       deq_lv_q;
  logic                byp_q;
  logic [TW-1:0]       byp_data_q;
  logic [TW-1:0]       res_chosen_q;
  status_t             res_status_q;

  logic                do_deq;
  logic [TW-1:0]       chosen_c;
  status_t             status_c;

  assign tid_in   = wrap_tid(task_id);
  assign lv_in    = (int'(task_prio) >= PRIO_LEVELS) ? LW'(PRIO_LEVELS - 1) : LW'(task_prio);
  assign req_stall = state != S_IDLE;
  assign acc      = req_valid && (state == S_IDLE);
  assign out_free = !res_valid || !res_stall;

  assign found[0] = 1'b0;

  for (genvar g = 0; g < PRIO_LEVELS; g++) begin : g_cell
    prqs_cell #(
      .LEVEL (g),
      .LW    (LW),
      .TW    (TW)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctl       (ctl),
      .enq_lv    (lv_in),
      .deq_lv    (deq_lv),
      .tid       (tid_in),
      .head_val  (head_val),
      .found_in  (found[g]),
      .found_out (found[g+1]),
      .is_top    (is_top[g]),
      .busy      (cell_busy[g]),
      .head      (cell_head[g]),
      .tail      (cell_tail[g])
    );
  end

  always_comb begin
    top_lv   = '0;
    top_head = '0;
    top_tail = '0;
    lv_busy  = 1'b0;
    lv_tail  = '0;
    for (int i = 0; i < PRIO_LEVELS; i++) begin
      if (is_top[i]) begin
        top_lv   = top_lv | LW'(i);
        top_head = top_head | cell_head[i];
        top_tail = top_tail | cell_tail[i];
      end
      if (LW'(i) == lv_in) begin
        lv_busy = lv_busy | cell_busy[i];
        lv_tail = lv_tail | cell_tail[i];
      end
    end
  end

  assign top_none = !found[PRIO_LEVELS];
  assign top_idx  = top_none ? RW'(PRIO_LEVELS) : RW'(top_lv);

  always_comb begin
    ctl         = '0;
    deq_lv      = top_lv;
    head_val    = byp_q ? byp_data_q : ram_q;
    ram_we      = 1'b0;
    ram_waddr   = lv_tail;
    ram_raddr   = top_head;
    do_deq      = 1'b0;
    chosen_c    = '0;
    status_c    = ST_DONE;
    locked_next = locked;
    tail_after  = (RW'(lv_in) == top_idx) ? tid_in : top_tail;
    state_next  = state;
    unique case (state)
      S_IDLE: begin
        if (acc) begin
          state_next = S_FIN;
          unique case (req_type)
            REQ_ADD: begin
              ctl.enq = 1'b1;
              ram_we  = lv_busy;
            end
            REQ_PICK: begin
              if (top_none) begin
                status_c = ST_EMPTY;
              end else begin
                do_deq     = 1'b1;
                tail_after = top_tail;
              end
            end
            REQ_SWITCH: begin
              if (locked) begin
                status_c = ST_DEFERRED;
                chosen_c = tid_in;
              end else if (top_none || (RW'(lv_in) < top_idx)) begin
                status_c = ST_KEPT;
                chosen_c = tid_in;
              end else begin
                ctl.enq = 1'b1;
                ram_we  = lv_busy;
                do_deq  = 1'b1;
              end
            end
            REQ_LOCK: begin
              if (locked) begin
                status_c = ST_LOCKED;
              end else begin
                locked_next = 1'b1;
              end
            end
            REQ_UNLOCK: begin
              if (!locked) begin
                status_c = ST_UNLOCKED;
              end else begin
                locked_next = 1'b0;
              end
            end
            default: begin
              status_c = ST_DONE;
            end
          endcase
          if (do_deq) begin
            chosen_c = top_head;
            if (top_head == tail_after) begin
              ctl.clr = 1'b1;
            end else begin
              state_next = S_LINK;
            end
          end
        end
      end
      S_LINK: begin
        ctl.hld    = 1'b1;
        deq_lv     = deq_lv_q;
        state_next = out_free ? S_IDLE : S_FIN;
      end
      S_FIN: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  prqs_ram #(
    .WIDTH (TW),
    .DEPTH (TASK_SLOTS)
  ) u_link (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (tid_in),
    .raddr (ram_raddr),
    .rdata (ram_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      locked    <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      state  <= state_next;
      locked <= locked_next;
      if ((state == S_LINK || state == S_FIN) && out_free) begin
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      deq_lv_q     <= top_lv;
      byp_q        <= ram_we && (ram_waddr == ram_raddr);
      byp_data_q   <= tid_in;
      res_chosen_q <= chosen_c;
      res_status_q <= status_c;
    end
    if ((state == S_LINK || state == S_FIN) && out_free) begin
      chosen_task   <= CHOSEN_W'(res_chosen_q);
      status        <= res_status_q;
      ready_highest <= READY_W'(top_idx);
    end
  end

endmodule
`default_nettype wire

### bench/priority_ready_queue_scheduler_test.sv
// Self-checking bench for the priority ready queue scheduler: random handshakes, predicted results.
`timescale 1ns / 1ps
module priority_ready_queue_scheduler_test;
  import prqs_pkg::*;

  localparam int LEVELS = DEF_PRIO_LEVELS;
  localparam int SLOTS = DEF_TASK_SLOTS;
  localparam int RANDOM_REQS = 400;
  localparam int DRAIN_AT = 200;
  localparam logic [READY_W-1:0] NO_LEVEL = READY_W'(LEVELS);
  localparam logic [REQ_W-1:0] FIRST_SPARE = 3'd5;

  typedef struct packed {
    logic                            locked;
    logic [LEVELS-1:0]               busy;
    logic [SLOTS-1:0]                linked;
    logic [SLOTS-1:0][ID_W-1:0]      link;
    logic [LEVELS-1:0][ID_W-1:0]     head;
    logic [LEVELS-1:0][ID_W-1:0]     tail;
  } ready_queue_t;

  typedef struct packed {
    logic [CHOSEN_W-1:0] chosen;
    logic [STATUS_W-1:0] st;
    logic [READY_W-1:0]  ready;
  } sched_res_t;

  typedef struct packed {
    logic              drain;
    logic [REQ_W-1:0]  kind;
    logic [ID_W-1:0]   tid;
    logic [PRIO_W-1:0] prio;
  } sched_req_t;

  logic clk = 1'b1;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  logic [REQ_W-1:0] req_type = '0;
  logic [ID_W-1:0] task_id = '0;
  logic [PRIO_W-1:0] task_prio = '0;
  logic res_valid;
  logic res_stall = 1'b0;
  logic [CHOSEN_W-1:0] chosen_task;
  logic [STATUS_W-1:0] status;
  logic [READY_W-1:0] ready_highest;

  ready_queue_t rq;
  ready_queue_t plan_rq = '0;
  ready_queue_t live_rq = '0;
  logic blank_read;
  sched_req_t pending[$];
  sched_res_t expected_q[$];
  logic req_taken = 1'b0;
  int req_gap = 0;
  int stall_left = 0;
  int calm_left = 0;
  int mismatches = 0;

  priority_ready_queue_scheduler u_top (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req_type(req_type),
    .task_id(task_id),
    .task_prio(task_prio),
    .res_valid(res_valid),
    .res_stall(res_stall),
    .chosen_task(chosen_task),
    .status(status),
    .ready_highest(ready_highest)
  );

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  function automatic logic [READY_W-1:0] top_level_of(input logic [LEVELS-1:0] busy);
    logic [READY_W-1:0] lv_top;
    lv_top = NO_LEVEL;
    for (int lv = LEVELS - 1; lv >= 0; lv--) begin
      if (busy[lv]) lv_top = READY_W'(lv);
    end
    return lv_top;
  endfunction

  function automatic void enqueue_task(input logic [ID_W-1:0] tid, input logic [PRIO_W-1:0] lv);
    if (rq.busy[lv]) begin
      rq.link[rq.tail[lv]] = tid;
      rq.linked[rq.tail[lv]] = 1'b1;
      rq.tail[lv] = tid;
    end else begin
      rq.head[lv] = tid;
      rq.tail[lv] = tid;
      rq.busy[lv] = 1'b1;
    end
  endfunction

  function automatic logic [ID_W-1:0] dequeue_task(input logic [READY_W-1:0] lv);
    logic [ID_W-1:0] tid;
    tid = rq.head[lv];
    if (rq.head[lv] == rq.tail[lv]) begin
      rq.busy[lv] = 1'b0;
    end else begin
      if (!rq.linked[tid]) blank_read = 1'b1;
      rq.head[lv] = rq.link[tid];
    end
    return tid;
  endfunction

  function automatic sched_res_t sched_step(input logic [REQ_W-1:0] kind,
                                            input logic [ID_W-1:0] tid,
                                            input logic [PRIO_W-1:0] prio);
    sched_res_t r;
    logic [READY_W-1:0] top;
    r = '0;
    top = top_level_of(rq.busy);
    case (kind)
      REQ_ADD: begin
        enqueue_task(tid, prio);
      end
      REQ_PICK: begin
        if (top == NO_LEVEL) r.st = ST_EMPTY;
        else r.chosen = dequeue_task(top);
      end
      REQ_SWITCH: begin
        if (rq.locked) begin
          r.st = ST_DEFERRED;
          r.chosen = tid;
        end else if (top == NO_LEVEL || prio < top) begin
          r.st = ST_KEPT;
          r.chosen = tid;
        end else begin
          enqueue_task(tid, prio);
          r.chosen = dequeue_task(top_level_of(rq.busy));
        end
      end
      REQ_LOCK: begin
        if (rq.locked) r.st = ST_LOCKED;
        else rq.locked = 1'b1;
      end
      REQ_UNLOCK: begin
        if (!rq.locked) r.st = ST_UNLOCKED;
        else rq.locked = 1'b0;
      end
      default: begin
      end
    endcase
    r.ready = top_level_of(rq.busy);
    return r;
  endfunction

  function automatic int idle_len();
    int pick;
    pick = $urandom_range(0, 99);
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    if (pick < 3) calm_left = $urandom_range(20, 40);
    if (pick < 55) return 0;
    if (pick < 85) return $urandom_range(1, 3);
    if (pick < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Turn a request that would follow an unwritten link into an add.
  task automatic queue_request(input logic [REQ_W-1:0] kind, input logic [ID_W-1:0] tid,
                               input logic [PRIO_W-1:0] prio, input logic drain);
    sched_req_t item;
    rq = plan_rq;
    blank_read = 1'b0;
    void'(sched_step(kind, tid, prio));
    if (blank_read) begin
      kind = REQ_ADD;
      rq = plan_rq;
      void'(sched_step(kind, tid, prio));
    end
    plan_rq = rq;
    item.drain = drain;
    item.kind = kind;
    item.tid = tid;
    item.prio = prio;
    pending.push_back(item);
  endtask

  task automatic queue_random_requests();
    int count;
    int pick;
    logic [REQ_W-1:0] kind;
    logic [PRIO_W-1:0] prio;
    count = 0;
    while (count < RANDOM_REQS) begin
      pick = $urandom_range(0, 99);
      if (pick < 40) kind = REQ_ADD;
      else if (pick < 64) kind = REQ_PICK;
      else if (pick < 90) kind = REQ_SWITCH;
      else if (pick < 95) kind = REQ_LOCK;
      else if (pick < 99) kind = REQ_UNLOCK;
      else kind = REQ_W'(FIRST_SPARE + $urandom_range(0, 2));
      if ($urandom_range(0, 99) < 70) prio = PRIO_W'($urandom_range(0, 3));
      else prio = PRIO_W'($urandom_range(0, 31));
      queue_request(kind, ID_W'($urandom_range(0, 63)), prio,
                    count == 0 || count == DRAIN_AT);
      if (kind <= REQ_UNLOCK) count++;
    end
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t ns: %s expected %0d actual %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    req_taken <= !rst && req_valid && !req_stall;
    if (!rst && req_valid && !req_stall) begin
      rq = live_rq;
      expected_q.push_back(sched_step(req_type, task_id, task_prio));
      live_rq = rq;
    end
  end

  always @(negedge clk) begin
    sched_req_t next_req;
    if (rst) begin
      req_valid <= 1'b0;
    end else if (req_valid && !req_taken) begin
      // hold the request until it is taken
    end else if (req_gap > 0) begin
      req_gap--;
      req_valid <= 1'b0;
    end else if (pending.size() != 0 && !(pending[0].drain && expected_q.size() != 0)) begin
      next_req = pending.pop_front();
      req_type <= next_req.kind;
      task_id <= next_req.tid;
      task_prio <= next_req.prio;
      req_valid <= 1'b1;
      req_gap = idle_len();
    end else begin
      req_valid <= 1'b0;
    end
  end

  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      res_stall <= 1'b1;
    end else begin
      stall_left = idle_len();
      res_stall <= stall_left > 0;
      if (stall_left > 0) stall_left--;
    end
  end

  always @(posedge clk) begin
    sched_res_t want;
    if (!rst && res_valid && !res_stall) begin
      if (expected_q.size() == 0) begin
        $display("%0t ns: result with none expected, chosen_task %0d status %0d ready_highest %0d",
                 $time, chosen_task, status, ready_highest);
        mismatches++;
      end else begin
        want = expected_q.pop_front();
        check_field("chosen_task", int'(want.chosen), int'(chosen_task));
        check_field("status", int'(want.st), int'(status));
        check_field("ready_highest", int'(want.ready), int'(ready_highest));
      end
    end
  end

  initial begin
    queue_request(REQ_PICK, 0, 0, 1'b0);
    queue_request(REQ_SWITCH, 63, 31, 1'b0);
    queue_request(REQ_UNLOCK, 0, 0, 1'b0);
    queue_request(REQ_LOCK, 0, 0, 1'b0);
    queue_request(REQ_LOCK, 0, 0, 1'b0);
    queue_request(REQ_SWITCH, 10, 0, 1'b0);
    queue_request(REQ_UNLOCK, 0, 0, 1'b0);
    queue_request(REQ_ADD, 0, 0, 1'b0);
    queue_request(REQ_ADD, 63, 31, 1'b0);
    queue_request(REQ_ADD, 5, 31, 1'b0);
    queue_request(REQ_ADD, 42, 0, 1'b0);
    queue_request(REQ_ADD, 63, 0, 1'b0);
    queue_request(REQ_SWITCH, 7, 0, 1'b0);
    queue_request(REQ_SWITCH, 9, 31, 1'b0);
    queue_request(REQ_PICK, 0, 0, 1'b0);
    queue_request(REQ_PICK, 0, 0, 1'b0);
    queue_request(REQ_PICK, 0, 0, 1'b0);
    queue_request(REQ_SWITCH, 20, 1, 1'b0);
    queue_request(FIRST_SPARE, 63, 31, 1'b0);
    queue_request(REQ_W'(FIRST_SPARE + 1), 21, 10, 1'b0);
    queue_request(REQ_W'(FIRST_SPARE + 2), 42, 21, 1'b0);
    queue_request(REQ_PICK, 0, 0, 1'b0);
    queue_request(REQ_PICK, 0, 0, 1'b0);
    queue_request(REQ_PICK, 0, 0, 1'b0);
    queue_request(REQ_PICK, 0, 0, 1'b0);
    queue_random_requests();

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (pending.size() != 0 || req_valid) @(posedge clk);
    while (expected_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("priority_ready_queue_scheduler regression: pass");
    end else begin
      $display("priority_ready_queue_scheduler regression: fail");
    end
    $finish;
  end

  initial begin
    #1000000;
    $display("priority_ready_queue_scheduler regression: fail");
    $finish;
  end

endmodule
